/* src/lfmd_pkg.sv */
// Shared types, codes and register layout for the line follower move decider.
package lfmd_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    NAV_STOP   = 2'd0,
    NAV_SIMPLE = 2'd1,
    NAV_ADV    = 2'd2
  } nav_mode_e;

  typedef enum logic [2:0] {
    MV_STOP      = 3'd0,
    MV_STRAIGHT  = 3'd1,
    MV_ADJ_RIGHT = 3'd2,
    MV_ADJ_LEFT  = 3'd3,
    MV_RIGHT     = 3'd4,
    MV_LEFT      = 3'd5
  } move_e;

  localparam logic [3:0] LK_STRAIGHT = 4'd1;
  localparam logic [3:0] LK_LEFT     = 4'd2;
  localparam logic [3:0] LK_RIGHT    = 4'd3;
  localparam logic [3:0] LK_STOP     = 4'd4;
  localparam logic [3:0] LK_TJ1      = 4'd5;
  localparam logic [3:0] LK_TJ2      = 4'd6;
  localparam logic [3:0] LK_TJ3      = 4'd7;
  localparam logic [3:0] LK_FOURWAY  = 4'd8;
  localparam logic [3:0] LK_UTURN    = 4'd9;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_NAV_MODE    = 3'd0;
  localparam logic [2:0] REG_TURN_MIN    = 3'd1;
  localparam logic [2:0] REG_SETTLE      = 3'd2;
  localparam logic [2:0] REG_FRONT       = 3'd3;
  localparam logic [2:0] REG_FRONT_LEFT  = 3'd4;
  localparam logic [2:0] REG_FRONT_RIGHT = 3'd5;
  localparam logic [2:0] REG_RIGHT       = 3'd6;

  localparam logic [15:0] TurnMinRst     = 16'd500;
  localparam logic [15:0] SettleRst      = 16'd1000;
  localparam logic [7:0]  FrontRst       = 8'd1;
  localparam logic [7:0]  FrontLeftRst   = 8'd2;
  localparam logic [7:0]  FrontRightRst  = 8'd4;
  localparam logic [7:0]  RightRst       = 8'd8;

  typedef struct packed {
    nav_mode_e   nav_mode;
    logic [15:0] turn_min_ms;
    logic [15:0] settle_ms;
    logic [7:0]  front_mask;
    logic [7:0]  front_left_mask;
    logic [7:0]  front_right_mask;
    logic [7:0]  right_mask;
  } cfg_t;

  typedef struct packed {
    move_e       move;
    logic        turning;
    logic        just_turned;
    logic        settle_started;
    logic [31:0] timer_start;
  } nav_state_t;

endpackage

/* src/lfmd_cfg_regs.sv */
// APB configuration registers of the move decider.
module lfmd_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lfmd_pkg::AddrW-1:0]   paddr,
  input  logic [lfmd_pkg::DataW-1:0]   pwdata,
  output logic [lfmd_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output lfmd_pkg::cfg_t               cfg_o
);
  import lfmd_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[AddrW-1:2];
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_NAV_MODE:    cfg_d.nav_mode         = nav_mode_e'(pwdata[1:0]);
        REG_TURN_MIN:    cfg_d.turn_min_ms      = pwdata[15:0];
        REG_SETTLE:      cfg_d.settle_ms        = pwdata[15:0];
        REG_FRONT:       cfg_d.front_mask       = pwdata[7:0];
        REG_FRONT_LEFT:  cfg_d.front_left_mask  = pwdata[7:0];
        REG_FRONT_RIGHT: cfg_d.front_right_mask = pwdata[7:0];
        REG_RIGHT:       cfg_d.right_mask       = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NAV_MODE:    prdata = {30'd0, cfg_q.nav_mode};
      REG_TURN_MIN:    prdata = {16'd0, cfg_q.turn_min_ms};
      REG_SETTLE:      prdata = {16'd0, cfg_q.settle_ms};
      REG_FRONT:       prdata = {24'd0, cfg_q.front_mask};
      REG_FRONT_LEFT:  prdata = {24'd0, cfg_q.front_left_mask};
      REG_FRONT_RIGHT: prdata = {24'd0, cfg_q.front_right_mask};
      REG_RIGHT:       prdata = {24'd0, cfg_q.right_mask};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nav_mode         <= NAV_STOP;
      cfg_q.turn_min_ms      <= TurnMinRst;
      cfg_q.settle_ms        <= SettleRst;
      cfg_q.front_mask       <= FrontRst;
      cfg_q.front_left_mask  <= FrontLeftRst;
      cfg_q.front_right_mask <= FrontRightRst;
      cfg_q.right_mask       <= RightRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* src/lfmd_decide.sv */
// Navigation state and the per-word move decision.
module lfmd_decide (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  lfmd_pkg::cfg_t       cfg_i,
  input  logic [3:0]           line_kind_i,
  input  logic [7:0]           sensor_bits_i,
  input  logic [31:0]          now_ms_i,
  output lfmd_pkg::nav_state_t state_d_o
);
  import lfmd_pkg::*;

  nav_state_t  st_q, st_d;
  logic        front, fleft, fright, right_s;
  logic        advanced;
  logic [31:0] elapsed;

  assign front    = |(sensor_bits_i & cfg_i.front_mask);
  assign fleft    = |(sensor_bits_i & cfg_i.front_left_mask);
  assign fright   = |(sensor_bits_i & cfg_i.front_right_mask);
  assign right_s  = |(sensor_bits_i & cfg_i.right_mask);
  assign advanced = (cfg_i.nav_mode == NAV_ADV);
  // wrapping age of the shared timer
  assign elapsed  = now_ms_i - st_q.timer_start;

  always_comb begin
    st_d = st_q;
    case (cfg_i.nav_mode)
      NAV_STOP: st_d.move = MV_STOP;
      NAV_SIMPLE, NAV_ADV: begin
        case (st_q.move)
          MV_STRAIGHT, MV_ADJ_RIGHT, MV_ADJ_LEFT: begin
            if (st_q.just_turned) begin
              // settle window: ignore line kind, start timer on first word
              if (!st_q.settle_started) begin
                st_d.timer_start    = now_ms_i;
                st_d.settle_started = 1'b1;
              end else if (elapsed > {16'd0, cfg_i.settle_ms}) begin
                st_d.settle_started = 1'b0;
                st_d.just_turned    = 1'b0;
              end
            end else if (line_kind_i == LK_RIGHT ||
                         (advanced && (line_kind_i inside
                           {LK_TJ1, LK_TJ2, LK_FOURWAY, LK_UTURN}))) begin
              st_d.move = MV_RIGHT;
            end else if (advanced && line_kind_i == LK_TJ3) begin
              st_d.move = MV_STRAIGHT;
            end else if (line_kind_i == LK_LEFT) begin
              st_d.move = MV_LEFT;
            end else if (fright && !fleft && !front) begin
              st_d.move = MV_ADJ_RIGHT;
            end else if (!fright && fleft && !front) begin
              st_d.move = MV_ADJ_LEFT;
            end else if (line_kind_i == LK_STRAIGHT) begin
              st_d.move = MV_STRAIGHT;
            end else if (line_kind_i == LK_STOP) begin
              st_d.move = MV_STOP;
            end
          end
          MV_STOP: begin
            if (line_kind_i == LK_STRAIGHT) st_d.move = MV_STRAIGHT;
          end
          MV_RIGHT, MV_LEFT: begin
            if (!st_q.turning) begin
              // first word of the turn: timer starts now, nothing expires
              st_d.timer_start = now_ms_i;
              st_d.turning     = 1'b1;
              if (advanced && st_q.move == MV_LEFT && right_s) begin
                st_d.move    = MV_RIGHT;
                st_d.turning = 1'b0;
              end
            end else if (elapsed > {16'd0, cfg_i.turn_min_ms}) begin
              if (front) begin
                st_d.move        = MV_STRAIGHT;
                st_d.turning     = 1'b0;
                st_d.just_turned = 1'b1;
              end
            end else if (advanced && st_q.move == MV_LEFT && right_s) begin
              st_d.move    = MV_RIGHT;
              st_d.turning = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign state_d_o = st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.move           <= MV_STOP;
      st_q.turning        <= 1'b0;
      st_q.just_turned    <= 1'b0;
      st_q.settle_started <= 1'b0;
      st_q.timer_start    <= '0;
    end else if (advance_i) begin
      st_q <= st_d;
    end
  end

endmodule

/* src/line_follower_move_decider_unit.sv */
// Line follower move decider: one move command per line/sensor/time sample, with config over APB.
// Each accepted word (line kind, sensor bitmap, millisecond timestamp) yields exactly one result
// word (move command, in-turn flag). The unit takes one word every cycle while no result is held:
// the input register, the combinational navigation state update and the result register form a
// two-stage pipeline. A held result stalls the input register, which takes new words again once
// the result moves on. The move state and the shared turn/settle timer start live in one register
// set updated once per word. Configuration registers sit at byte addresses 0x00..0x18; the user
// must write them only while no word is in flight, which the unit itself does not enforce.
module line_follower_move_decider_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfmd_pkg::AddrW-1:0]  paddr,
  input  logic [lfmd_pkg::DataW-1:0]  pwdata,
  output logic [lfmd_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [3:0]                  line_kind_i,
  input  logic [7:0]                  sensor_bits_i,
  input  logic [31:0]                 now_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  move_cmd_o,
  output logic                        in_turn_o
);
  import lfmd_pkg::*;

  cfg_t        cfg;
  nav_state_t  st_d;

  logic        s1_valid_q, s1_valid_d;
  logic [3:0]  kind_q;
  logic [7:0]  bits_q;
  logic [31:0] now_q;
  logic        out_valid_q, out_valid_d;
  logic [2:0]  move_q;
  logic        turn_q;
  logic        out_free, advance, in_acc;

  lfmd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lfmd_decide u_decide (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .cfg_i         (cfg),
    .line_kind_i   (kind_q),
    .sensor_bits_i (bits_q),
    .now_ms_i      (now_q),
    .state_d_o     (st_d)
  );

  assign out_free    = !out_valid_q || out_ready_i;
  assign advance     = s1_valid_q && out_free;
  assign in_ready_o  = !s1_valid_q || advance;
  assign in_acc      = in_valid_i && in_ready_o;
  assign s1_valid_d  = in_acc || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload: hold unless a word moves in
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= line_kind_i;
      bits_q <= sensor_bits_i;
      now_q  <= now_ms_i;
    end
    if (advance) begin
      move_q <= st_d.move;
      turn_q <= st_d.turning;
    end
  end

  assign out_valid_o = out_valid_q;
  assign move_cmd_o  = move_q;
  assign in_turn_o   = turn_q;

  // a presented result carries a defined move code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (move_cmd_o <= MV_LEFT))
    else $error("result with an undefined move code");

  // a held input word is not dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q)
    else $error("input word lost while stalled");

  // a new result only follows an advance of the input stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance))
    else $error("result appeared without an advance");

  // a word taken into the input stage is pending next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted word not held in input stage");

endmodule
